// ----- design/cnlb_pkg.sv -----
// Shared types, constants and helper functions for the card number checker.
package cnlb_pkg;

  // Longest number length that can still carry a brand
  localparam int unsigned MAX_DIGITS = 19;

  localparam int unsigned CountW = 5;
  localparam logic [CountW-1:0] COUNT_SAT = '1;

  // Code kept for a leading character that is not a digit
  localparam logic [3:0] NON_DIGIT = 4'd15;

  // Brand codes
  localparam logic [3:0] BRAND_UNKNOWN    = 4'd0;
  localparam logic [3:0] BRAND_UP         = 4'd1;
  localparam logic [3:0] BRAND_MASTERCARD = 4'd2;
  localparam logic [3:0] BRAND_BANKCARD   = 4'd3;
  localparam logic [3:0] BRAND_VISA       = 4'd4;
  localparam logic [3:0] BRAND_AMEX       = 4'd5;
  localparam logic [3:0] BRAND_DISCOVER   = 4'd6;
  localparam logic [3:0] BRAND_DINERS     = 4'd7;
  localparam logic [3:0] BRAND_JCB        = 4'd8;

  typedef logic [3:0] digit_t;
  typedef logic [3:0][3:0] lead_t;

  typedef struct packed {
    logic [7:0] char_code;
    logic       last;
  } chr_t;

  typedef struct packed {
    logic                number_ok;
    logic                luhn_ok;
    logic [3:0]          card_brand;
    logic [CountW-1:0]   digit_count;
  } res_t;

  // Luhn doubling of one digit, folded back to a single digit
  function automatic digit_t luhn_double(input digit_t d);
    logic [4:0] twice;
    twice = {d, 1'b0};
    if (d > 4'd4) begin
      twice = twice - 5'd9;
    end
    return twice[3:0];
  endfunction

  // Sum of two values below ten, modulo ten
  function automatic digit_t add_mod10(input digit_t a, input digit_t b);
    logic [4:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= 5'd10) begin
      s = s - 5'd10;
    end
    return s[3:0];
  endfunction

endpackage

// ----- design/cnlb_brand.sv -----
// Brand decode from the number length and the first four digits.
module cnlb_brand (
  input  logic [cnlb_pkg::CountW-1:0] count,
  input  cnlb_pkg::lead_t             lead,
  output logic [3:0]                  brand
);
  import cnlb_pkg::*;

  digit_t a, b, c, e;
  logic   len13, len14, len15, len16, len19;

  assign a = lead[0];
  assign b = lead[1];
  assign c = lead[2];
  assign e = lead[3];

  assign len13 = (count == CountW'(13));
  assign len14 = (count == CountW'(14));
  assign len15 = (count == CountW'(15));
  assign len16 = (count == CountW'(16));
  assign len19 = (count == CountW'(19));

  // Try the prefix rules in priority order; first match wins
  always_comb begin
    priority if (count > CountW'(MAX_DIGITS)) begin
      brand = BRAND_UNKNOWN;
    end else if ((len16 || len19) && a == 4'd6) begin
      brand = BRAND_UP;
    end else if (len16 && a == 4'd5 && b != 4'd0 && b <= 4'd5) begin
      brand = BRAND_MASTERCARD;
    end else if (len16 && a == 4'd5 && b == 4'd6 && c <= 4'd1) begin
      brand = BRAND_BANKCARD;
    end else if ((len16 || len13) && a == 4'd4) begin
      brand = BRAND_VISA;
    end else if (len15 && a == 4'd3 && (b == 4'd4 || b == 4'd7)) begin
      brand = BRAND_AMEX;
    end else if (len16 && a == 4'd6 && b == 4'd0 && c == 4'd1 && e == 4'd1) begin
      brand = BRAND_DISCOVER;
    end else if (len14 && a == 4'd3 && (b == 4'd0 || b == 4'd6 || b == 4'd8) &&
                 (b != 4'd0 || c <= 4'd5)) begin
      brand = BRAND_DINERS;
    end else if ((len16 || len15) && a == 4'd3 && b == 4'd5) begin
      brand = BRAND_JCB;
    end else begin
      brand = BRAND_UNKNOWN;
    end
  end

endmodule

// ----- design/cnlb_accum.sv -----
// Per-number running state: count, Luhn sums, digit flag and leading digits.
module cnlb_accum (
  input  logic           clk,
  input  logic           rst,
  input  logic           step,
  input  cnlb_pkg::chr_t item,
  output cnlb_pkg::res_t result
);
  import cnlb_pkg::*;

  logic [CountW-1:0] char_total, char_total_next;
  digit_t            sum_even, sum_even_next;
  digit_t            sum_odd, sum_odd_next;
  logic              all_digits, all_digits_next;
  lead_t             lead, lead_next;

  logic   is_digit;
  digit_t d, d_dbl;
  logic [3:0] brand;

  // Classify the character
  assign is_digit = (item.char_code >= 8'd48) && (item.char_code <= 8'd57);
  assign d        = is_digit ? 4'(item.char_code - 8'd48) : 4'd0;
  assign d_dbl    = luhn_double(d);

  // Fold the character into the running state
  always_comb begin
    char_total_next = char_total;
    sum_even_next   = sum_even;
    sum_odd_next    = sum_odd;
    all_digits_next = all_digits && is_digit;
    lead_next       = lead;
    if (char_total < CountW'(4)) begin
      lead_next[char_total[1:0]] = is_digit ? d : NON_DIGIT;
    end
    if (char_total != COUNT_SAT) begin
      if (!char_total[0]) begin
        sum_even_next = add_mod10(sum_even, d_dbl);
        sum_odd_next  = add_mod10(sum_odd, d);
      end else begin
        sum_even_next = add_mod10(sum_even, d);
        sum_odd_next  = add_mod10(sum_odd, d_dbl);
      end
      char_total_next = char_total + CountW'(1);
    end
  end

  cnlb_brand u_brand (
    .count (char_total_next),
    .lead  (lead_next),
    .brand (brand)
  );

  // Build the result from the updated state
  always_comb begin
    result.number_ok   = all_digits_next && (char_total_next <= CountW'(16));
    result.luhn_ok     = char_total_next[0] ? (sum_odd_next == 4'd0)
                                            : (sum_even_next == 4'd0);
    result.card_brand  = brand;
    result.digit_count = char_total_next;
  end

  // Advance on each beat; clear after the closing character
  always_ff @(posedge clk) begin
    if (rst || (step && item.last)) begin
      char_total <= '0;
      sum_even   <= '0;
      sum_odd    <= '0;
      all_digits <= 1'b1;
      lead       <= '0;
    end else if (step) begin
      char_total <= char_total_next;
      sum_even   <= sum_even_next;
      sum_odd    <= sum_odd_next;
      all_digits <= all_digits_next;
      lead       <= lead_next;
    end
  end

endmodule

// ----- design/card_number_luhn_and_brand_check_top.sv -----
// Top level of the card number Luhn and brand checker.
//
// Input channel chr_*: one ASCII character per beat, with last set on the
// final character of a card number. Output channel res_*: one result beat
// per number, carrying number_ok, luhn_ok, card_brand and digit_count.
// A beat moves on a rising edge with valid high and stall low.
//
// Characters pass through an input register, are folded into the running
// count, Luhn sums and leading digits, and the closing character loads the
// result register as it leaves the input register. One character is taken
// every cycle while no closing character waits on a stalled result;
// characters that are not last keep flowing while a result waits to be taken.
//
// Reset (rst, synchronous) empties both registers and returns the running
// state to an empty number. While the receiver stalls a waiting result, the
// result holds, and a closing character stays in the input register, which
// stalls the input channel until the result is taken.
module card_number_luhn_and_brand_check_top (
  input  logic           clk,
  input  logic           rst,
  input  logic           chr_valid,
  output logic           chr_stall,
  input  cnlb_pkg::chr_t chr_data,
  output logic           res_valid,
  input  logic           res_stall,
  output cnlb_pkg::res_t res_data
);
  import cnlb_pkg::*;

  logic  s1_valid;
  chr_t  s1_data;
  logic  advance;
  res_t  result;

  // Move the held character on unless it closes a number and the result is blocked
  assign advance   = s1_valid && (!s1_data.last || !res_valid || !res_stall);
  assign chr_stall = s1_valid && !advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (chr_valid && !chr_stall) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (chr_valid && !chr_stall) begin
      s1_data <= chr_data;
    end
  end

  cnlb_accum u_accum (
    .clk    (clk),
    .rst    (rst),
    .step   (advance),
    .item   (s1_data),
    .result (result)
  );

  // Result register: load on a closing character, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance && s1_data.last) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_data.last) begin
      res_data <= result;
    end
  end

endmodule

// ----- design/cnlb_checker.sv -----
// Port-level checks on the card number checker, bound to its top level.
module cnlb_checker (
  input logic           clk,
  input logic           rst,
  input logic           chr_stall,
  input cnlb_pkg::res_t res_data,
  input logic           res_valid,
  input logic           res_stall
);
  import cnlb_pkg::*;

  // Hold a stalled result beat
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(res_data))
    else $error("stalled result dropped or changed");

  // Nothing comes out right after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !res_valid)
    else $error("result valid after reset");

  // Input stalls only behind a blocked result
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    chr_stall |-> res_valid && res_stall)
    else $error("input stalled with no blocked result");

  // A good number never exceeds sixteen characters
  a_ok_len: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_data.number_ok |-> res_data.digit_count <= CountW'(16))
    else $error("number_ok on an overlong number");

  // Brands only on lengths that some rule allows
  a_brand_len: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_data.card_brand != BRAND_UNKNOWN |->
      res_data.digit_count == CountW'(13) || res_data.digit_count == CountW'(14) ||
      res_data.digit_count == CountW'(15) || res_data.digit_count == CountW'(16) ||
      res_data.digit_count == CountW'(19))
    else $error("brand on a length no rule covers");

endmodule

bind card_number_luhn_and_brand_check_top cnlb_checker u_cnlb_checker (
  .clk       (clk),
  .rst       (rst),
  .chr_stall (chr_stall),
  .res_data  (res_data),
  .res_valid (res_valid),
  .res_stall (res_stall)
);
